/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/eed_pkg.sv */
// ----------------------------------------------------------------------------
// eed_pkg
// Types and constants of the echo escape decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eed_pkg;

	// input commands
	localparam logic [1:0] CMD_CHAR    = 2'd0;
	localparam logic [1:0] CMD_END_ARG = 2'd1;
	localparam logic [1:0] CMD_END_ALL = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_STOP = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_STOP    = 8'h63; // 'c'
	localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
	localparam logic [4:0] OCT_DIGIT_HI = 5'b00110; // '0'..'7' share these upper bits

	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
	localparam logic [8:0] BYTE_MAX       = 9'd255;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESCAPE = 2'd1,
		MODE_OCTAL  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} result_t;

	typedef struct packed {
		mode_t      mode;
		logic [8:0] oval;
		logic [1:0] odig;
		logic [1:0] halt;
	} state_t;

	localparam state_t STATE_RESET = '{mode: MODE_NORMAL, oval: 9'd0, odig: 2'd0,
		halt: ST_OK};

	// up to two results of one item, in order
	typedef struct packed {
		logic [1:0] n;
		result_t    a;
		result_t    b;
	} res_pair_t;

	typedef struct packed {
		res_pair_t pair;
		state_t    nxt;
	} dec_out_t;

endpackage

`default_nettype wire

/* sv/eed_decode.sv */
// ----------------------------------------------------------------------------
// eed_decode
// Combinational escape decoding of one item: results and next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eed_decode import eed_pkg::*; (
	input  item_t    item,
	input  state_t   cur,
	output dec_out_t dec
);

	function automatic result_t mk(input logic has, input logic [7:0] b,
		input logic [1:0] st);
		result_t r;
		r.has_byte = has;
		r.out_byte = b;
		r.status   = st;
		r.last     = 1'b0;
		return r;
	endfunction

	// {hit, byte} for the single-letter control escapes
	function automatic logic [8:0] esc_byte(input logic [7:0] c);
		logic [8:0] v;
		case (c)
			8'h61:   v = {1'b1, 8'd7};   // a
			8'h62:   v = {1'b1, 8'd8};   // b
			8'h66:   v = {1'b1, 8'd12};  // f
			8'h6E:   v = {1'b1, 8'd10};  // n
			8'h72:   v = {1'b1, 8'd13};  // r
			8'h74:   v = {1'b1, 8'd9};   // t
			8'h76:   v = {1'b1, 8'd11};  // v
			8'h5C:   v = {1'b1, 8'd92};  // backslash
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	state_t     nxt;
	result_t    ra;
	result_t    rb;
	logic [1:0] n;
	logic       is_dig;
	logic [8:0] nv;
	logic [1:0] ndig;
	logic [8:0] esc;
	result_t    plain;
	logic       plain_emits;

	assign is_dig = (item.ch[7:3] == OCT_DIGIT_HI);
	assign nv     = {cur.oval[5:0], item.ch[2:0]};
	assign ndig   = cur.odig + 2'd1;
	assign esc    = esc_byte(item.ch);
	assign plain  = mk(1'b1, item.ch, ST_OK);
	assign plain_emits = (item.ch != CH_BSLASH);

	always_comb begin
		nxt = cur;
		ra  = '0;
		rb  = '0;
		n   = 2'd0;
		case (item.cmd)
			CMD_END_ALL: begin
				if (cur.halt == ST_OK) begin
					unique case (cur.mode)
						MODE_ESCAPE: begin
							ra = mk(1'b0, 8'd0, ST_ERR);
							n  = 2'd1;
						end
						MODE_OCTAL: begin
							ra = mk(1'b1, cur.oval[7:0], ST_OK);
							rb = mk(1'b1, CH_NEWLINE, ST_OK);
							n  = 2'd2;
						end
						default: begin
							ra = mk(1'b1, CH_NEWLINE, ST_OK);
							n  = 2'd1;
						end
					endcase
				end
				nxt = STATE_RESET;
			end
			CMD_END_ARG: begin
				if (cur.halt == ST_OK) begin
					nxt.mode = MODE_NORMAL;
					nxt.oval = 9'd0;
					nxt.odig = 2'd0;
					unique case (cur.mode)
						MODE_ESCAPE: begin
							ra       = mk(1'b0, 8'd0, ST_ERR);
							n        = 2'd1;
							nxt.halt = ST_ERR;
						end
						MODE_OCTAL: begin
							ra = mk(1'b1, cur.oval[7:0], ST_OK);
							n  = 2'd1;
						end
						default: begin
							nxt.oval = cur.oval;
							nxt.odig = cur.odig;
						end
					endcase
				end
			end
			CMD_CHAR: begin
				if (cur.halt == ST_OK) begin
					unique case (cur.mode)
						MODE_ESCAPE: begin
							nxt.mode = MODE_NORMAL;
							if (esc[8]) begin
								ra = mk(1'b1, esc[7:0], ST_OK);
								n  = 2'd1;
							end else if (item.ch == CH_STOP) begin
								ra       = mk(1'b0, 8'd0, ST_STOP);
								n        = 2'd1;
								nxt.halt = ST_STOP;
								nxt.oval = 9'd0;
								nxt.odig = 2'd0;
							end else if (item.ch == CH_ZERO) begin
								nxt.mode = MODE_OCTAL;
								nxt.oval = 9'd0;
								nxt.odig = 2'd0;
							end
						end
						MODE_OCTAL: begin
							if (is_dig) begin
								nxt.oval = nv;
								nxt.odig = ndig;
								if (ndig == OCT_MAX_DIGITS) begin
									nxt.mode = MODE_NORMAL;
									nxt.oval = 9'd0;
									nxt.odig = 2'd0;
									n        = 2'd1;
									if (nv > BYTE_MAX) begin
										ra       = mk(1'b0, 8'd0, ST_ERR);
										nxt.halt = ST_ERR;
									end else begin
										ra = mk(1'b1, nv[7:0], ST_OK);
									end
								end
							end else begin
								// flush the pending value, then treat the byte as plain
								ra       = mk(1'b1, cur.oval[7:0], ST_OK);
								nxt.oval = 9'd0;
								nxt.odig = 2'd0;
								if (plain_emits) begin
									rb       = plain;
									n        = 2'd2;
									nxt.mode = MODE_NORMAL;
								end else begin
									n        = 2'd1;
									nxt.mode = MODE_ESCAPE;
								end
							end
						end
						default: begin
							if (plain_emits) begin
								ra       = plain;
								n        = 2'd1;
								nxt.mode = MODE_NORMAL;
							end else begin
								nxt.mode = MODE_ESCAPE;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		ra.last = (n == 2'd1);
		rb.last = 1'b1;
	end

	assign dec.pair.n = n;
	assign dec.pair.a = ra;
	assign dec.pair.b = rb;
	assign dec.nxt    = nxt;

endmodule

`default_nettype wire

/* sv/eed_result_queue.sv */
// ----------------------------------------------------------------------------
// eed_result_queue
// Small result queue: takes up to two results a cycle, hands out one while not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module eed_result_queue import eed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t pair,
	output logic      full,
	output logic      valid,
	input  logic      stall,
	output result_t   data
);

	result_t        q_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           pop;
	logic [QAW-1:0] wr_b;

	assign pop   = valid && !stall;
	assign valid = (cnt_q != '0);
	assign data  = q_q[rd_q];
	// room for a full pair must exist before the next item is taken
	assign full  = (cnt_q > (QAW+1)'(QDEPTH - 2));
	assign wr_b  = wr_q + QAW'(1);

	always_ff @(posedge clk) begin
		if (pair.n != 2'd0) begin
			q_q[wr_q] <= pair.a;
		end
		if (pair.n == 2'd2) begin
			q_q[wr_b] <= pair.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QAW'(pair.n);
			rd_q  <= rd_q + QAW'(pop);
			cnt_q <= cnt_q + (QAW+1)'(pair.n) - (QAW+1)'(pop);
		end
	end

	`ASSERT_HOLDS(a_cnt_range, clk, arst_n, cnt_q <= (QAW+1)'(QDEPTH), "queue count overrun")
	`ASSERT_IMPLIES(a_push_room, clk, arst_n, pair.n != 2'd0, !full, "push into full queue")
	`ASSERT_NEXT(a_pop_only, clk, arst_n, pop && pair.n == 2'd0, cnt_q == $past(cnt_q) - (QAW+1)'(1), "pop did not drain")

endmodule

`default_nettype wire

/* sv/echo_escape_decoder_core.sv */
// ----------------------------------------------------------------------------
// echo_escape_decoder_core
// Decodes echo-style backslash escapes in a byte stream.
// ----------------------------------------------------------------------------
//  channel  | dir | payload  | handshake
//  item     | in  | item_t   | item_valid / item_stall
//  result   | out | result_t | result_valid / result_stall
//
// One item is taken per cycle while item_stall is low; its 0..2 results are
// decoded in the same cycle and written into a four-entry result queue that
// hands them out in order. item_stall rises while the queue has fewer than two
// free entries; results leave one per cycle while result_stall is low.
// Reset clears the escape state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module echo_escape_decoder_core import eed_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	state_t    state_q;
	dec_out_t  dec;
	res_pair_t push;
	logic      accept;
	logic      full;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	eed_decode u_dec (
		.item (item),
		.cur  (state_q),
		.dec  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= dec.nxt;
		end
	end

	always_comb begin
		push = dec.pair;
		if (!accept) begin
			push.n = 2'd0;
		end
	end

	eed_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (push),
		.full   (full),
		.valid  (result_valid),
		.stall  (result_stall),
		.data   (result)
	);

	`ASSERT_IMPLIES(a_empty_status, clk, arst_n, result_valid && !result.has_byte, result.status != ST_OK, "byteless result with ok status")
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, item_stall, result_valid, "stall with no pending result")
	`ASSERT_IMPLIES(a_halt_mode, clk, arst_n, state_q.halt != ST_OK, state_q.mode == MODE_NORMAL, "halted inside an escape")

endmodule

`default_nettype wire
